// ----- hdl/shs_pkg.sv -----
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_MAX = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] RND_MAX  = 6'(ROUNDS - 1);
  localparam logic [1:0] WORD_MAX = 2'd3;

  typedef logic [0:7][31:0] words8_t;

  localparam words8_t SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } shs_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } shs_out_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_DONE  = 5'b10000
  } shs_state_t;

  typedef struct packed {
    logic       push_in;
    logic       push_pad;
    logic       pad_mark;
    logic       pad_len;
    logic       load_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_chain;
    logic       finish;
  } shs_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } shs_status_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/shs_ctrl.sv -----
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: byte intake, 64 round steps, chain update, padding and digest
// hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module shs_ctrl import shs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  shs_in_t     in_data,
  input  shs_status_t status,
  output shs_cmd_t    cmd
);

  shs_state_t st_r, st_nxt;
  logic [5:0] round_r, round_nxt;
  logic       fin_r, fin_nxt;
  logic       final_r, final_nxt;
  logic       mark_r, mark_nxt;
  logic       lenph_r, lenph_nxt;
  logic       len_byte;

  assign in_stall = (st_r != ST_IDLE);
  assign len_byte = mark_r && (lenph_r || status.fill == LEN_POS);

  always_comb begin
    st_nxt        = st_r;
    round_nxt     = round_r;
    fin_nxt       = fin_r;
    final_nxt     = final_r;
    mark_nxt      = mark_r;
    lenph_nxt     = lenph_r;
    cmd           = '0;
    cmd.round_idx = round_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          mark_nxt  = 1'b0;
          lenph_nxt = 1'b0;
          if (in_data.has_byte) begin
            cmd.push_in = 1'b1;
            if (status.fill == FILL_MAX) begin
              cmd.load_work = 1'b1;
              round_nxt     = '0;
              fin_nxt       = in_data.end_of_message;
              st_nxt        = ST_ROUND;
            end else if (in_data.end_of_message) begin
              st_nxt = ST_PAD;
            end
          end else if (in_data.end_of_message) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == RND_MAX) begin
          st_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        if (final_r) begin
          st_nxt = ST_DONE;
        end else if (fin_r) begin
          st_nxt = ST_PAD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.push_pad = 1'b1;
        if (!mark_r) begin
          cmd.pad_mark = 1'b1;
          mark_nxt     = 1'b1;
        end else if (len_byte) begin
          cmd.pad_len = 1'b1;
          lenph_nxt   = 1'b1;
        end
        if (status.fill == FILL_MAX) begin
          cmd.load_work = 1'b1;
          round_nxt     = '0;
          fin_nxt       = 1'b1;
          final_nxt     = len_byte;
          st_nxt        = ST_ROUND;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          fin_nxt    = 1'b0;
          final_nxt  = 1'b0;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      round_r <= '0;
      fin_r   <= 1'b0;
      final_r <= 1'b0;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      round_r <= round_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
    end
  end

  a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROUND && round_r == RND_MAX) |=> st_r == ST_ADD)
    else $error("compression did not end after the last round");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && !status.out_busy) |=> st_r == ST_IDLE)
    else $error("digest hand-off did not return to idle");

  a_final_has_fin: assert property (@(posedge clk) disable iff (!rst_n)
    final_r |-> fin_r)
    else $error("final block flagged outside a finishing message");

endmodule

// ----- hdl/shs_datapath.sv -----
// ----------------------------------------------------------------------------
// shs_datapath
// Message window, round registers, chaining words, bit count and the digest
// output buffer.
// ----------------------------------------------------------------------------
module shs_datapath import shs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  shs_cmd_t    cmd,
  input  logic [7:0]  in_byte,
  output shs_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output shs_out_t    out_data
);

  logic [511:0] win_r, win_nxt;
  words8_t      v_r, v_nxt;
  words8_t      chain_r, chain_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [255:0] obuf_r, obuf_nxt;
  logic [1:0]   ocnt_r, ocnt_nxt;
  logic         ovld_r, ovld_nxt;
  logic [7:0]   len_sel, byte_sel;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, ch, maj;
  logic         out_take;

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sigma1(v_r[4]) + ch + round_k(cmd.round_idx) + w0;
  assign t2  = big_sigma0(v_r[0]) + maj;

  assign len_sel  = 8'(bits_r >> {~fill_r[2:0], 3'b000});
  assign byte_sel = cmd.push_in  ? in_byte  :
                    cmd.pad_mark ? PAD_MARK :
                    cmd.pad_len  ? len_sel  : 8'h00;

  assign out_take = ovld_r && !out_stall;

  always_comb begin
    win_nxt   = win_r;
    v_nxt     = v_r;
    chain_nxt = chain_r;
    bits_nxt  = bits_r;
    fill_nxt  = fill_r;
    obuf_nxt  = obuf_r;
    ocnt_nxt  = ocnt_r;
    ovld_nxt  = ovld_r;
    if (cmd.push_in || cmd.push_pad) begin
      win_nxt  = {win_r[503:0], byte_sel};
      fill_nxt = fill_r + 6'd1;
    end
    if (cmd.push_in) begin
      bits_nxt = bits_r + 64'd8;
    end
    if (cmd.load_work) begin
      v_nxt = chain_r;
    end
    if (cmd.round_en) begin
      win_nxt = {win_r[479:0], w_new};
      v_nxt   = {t1 + t2, v_r[0], v_r[1], v_r[2], v_r[3] + t1, v_r[4], v_r[5], v_r[6]};
    end
    if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + v_r[i];
      end
    end
    if (out_take) begin
      obuf_nxt = {obuf_r[191:0], 64'h0};
      ocnt_nxt = ocnt_r + 2'd1;
      if (ocnt_r == WORD_MAX) begin
        ovld_nxt = 1'b0;
      end
    end
    if (cmd.finish) begin
      obuf_nxt  = chain_r;
      ocnt_nxt  = '0;
      ovld_nxt  = 1'b1;
      chain_nxt = SHA_IV;
      bits_nxt  = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= SHA_IV;
      bits_r  <= '0;
      fill_r  <= '0;
      ocnt_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      chain_r <= chain_nxt;
      bits_r  <= bits_nxt;
      fill_r  <= fill_nxt;
      ocnt_r  <= ocnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    v_r    <= v_nxt;
    obuf_r <= obuf_nxt;
  end

  assign status.fill     = fill_r;
  assign status.out_busy = ovld_r;

  assign out_valid            = ovld_r;
  assign out_data.digest_word = obuf_r[255:192];
  assign out_data.word_index  = ocnt_r;
  assign out_data.last_word   = (ocnt_r == WORD_MAX);

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !ovld_r)
    else $error("digest loaded over a pending result");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && ocnt_r == WORD_MAX) |=> !ovld_r)
    else $error("result stayed valid after the last word");

  a_no_push_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !(cmd.push_in || cmd.push_pad))
    else $error("byte pushed during a round step");

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 hasher: one message byte per request, 256-bit digest
// returned as four 64-bit big-endian words.
//
//   channel  direction  payload
//   in_      input      shs_in_t  (message_byte, has_byte, end_of_message)
//   out_     output     shs_out_t (digest_word, word_index, last_word)
//
// Requests are taken back to back, but every 64th byte first runs the 64
// rounds of the single round unit plus the chaining add before the next one.
// Finishing pushes the padding bytes (9 to 72), compresses each padded block
// and then loads the digest into the output buffer.
// The four result words drain while new requests are taken; a finish waits
// only while a previous digest is still pending. Reset is synchronous.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import shs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  shs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output shs_out_t out_data
);

  shs_cmd_t    cmd;
  shs_status_t status;

  shs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  shs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_byte   (in_data.message_byte),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/sha256_digest_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the streaming SHA-256 hasher. Each accepted request
// is fed into a local SHA-256 (FIPS 180-4) model. A finishing request queues
// the four expected digest words, and each accepted word is compared field by
// field with the oldest one. Mismatches are printed and counted.
// ----------------------------------------------------------------------------
module sha256_digest_checker import shs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  shs_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  shs_out_t out_data,
  output int       fail_count,
  output int       words_pending
);

  localparam logic [0:7][31:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_chain [8];
  logic [63:0] bit_total;
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;
  shs_out_t    digest_q [$];
  int          mism = 0;
  int          pend_n = 0;

  assign fail_count    = mism;
  assign words_pending = pend_n;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_chain[i] = HASH_INIT[i];
    bit_total = '0;
    blk_fill = '0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_blk();
  endfunction

  function automatic void close_message();
    logic [63:0] len;
    shs_out_t    word;
    len = bit_total;
    absorb_byte(8'h80);
    while (blk_fill != 6'd56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
    for (int k = 0; k < 4; k++) begin
      word.digest_word = {hash_chain[2*k], hash_chain[2*k+1]};
      word.word_index  = 2'(k);
      word.last_word   = (k == 3);
      digest_q.push_back(word);
    end
    restart_hash();
  endfunction

  function automatic void take_request(input shs_in_t req);
    if (req.has_byte) begin
      bit_total = bit_total + 64'd8;
      absorb_byte(req.message_byte);
    end
    if (req.end_of_message) close_message();
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mism++;
  endtask

  task automatic check_word(input shs_out_t got);
    shs_out_t want;
    if (digest_q.size() == 0) begin
      report("unexpected digest word", got.digest_word, '0);
      return;
    end
    want = digest_q.pop_front();
    if (got.digest_word !== want.digest_word)
      report("digest_word", got.digest_word, want.digest_word);
    if (got.word_index !== want.word_index)
      report("word_index", 64'(got.word_index), 64'(want.word_index));
    if (got.last_word !== want.last_word)
      report("last_word", 64'(got.last_word), 64'(want.last_word));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_hash();
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) check_word(out_data);
      if (in_valid && !in_stall) take_request(in_data);
    end
    pend_n <= digest_q.size();
  end

endmodule

// ----- dv/tb_sha256_stream_hasher.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives messages into the streaming SHA-256 hasher: directed cases (empty
// message, end with and without a byte, idle requests, extreme byte values)
// followed by random messages whose lengths hit the padding and block
// boundaries. Both sides insert random gaps; the checker counts the mismatches.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher import shs_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  shs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  shs_out_t out_data;
  int       fail_count;
  int       words_pending;

  bit       calm = 1'b0;
  int       n_items = 0;
  int       n_msgs = 0;
  int       cyc = 0;
  int       stall_left = 0;
  int       free_left = 0;

  sha256_stream_hasher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sha256_digest_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 10);
    if (r < 85) return $urandom_range(11, 40);
    case ($urandom_range(0, 7))
      0: return 55;
      1: return 56;
      2: return 57;
      3: return 63;
      4: return 64;
      5: return 65;
      6: return 119;
      default: return 120;
    endcase
  endfunction

  // hold off the result side in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left = free_left - 1;
    end else begin
      out_stall <= 1'b0;
      free_left = $urandom_range(0, 7);
      stall_left = calm ? 0 : pick_idle();
    end
  end

  task automatic send_req(input logic [7:0] b, input logic hb, input logic eom);
    int gap;
    gap = calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{message_byte: b, has_byte: hb, end_of_message: eom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hb || eom) n_items++;
  endtask

  task automatic send_msg(input int len, input bit tail_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(8'($urandom), 1'b0, 1'b0);
      send_req(8'($urandom), 1'b1, tail_byte && (i == len - 1));
    end
    if (!tail_byte || len == 0) send_req(8'($urandom), 1'b0, 1'b1);
    n_msgs++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then an idle request before another empty message
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'hff, 1'b0, 1'b0);
    send_req(8'hff, 1'b0, 1'b1);
    // end carried on the last byte
    send_req(8'h61, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0);
    send_req(8'h63, 1'b1, 1'b1);
    send_req(8'h00, 1'b1, 1'b1);
    send_req(8'hff, 1'b1, 1'b1);
    // end without a byte after data, idle request in the middle
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h5a, 1'b0, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h7f, 1'b1, 1'b0);
    send_req(8'ha5, 1'b0, 1'b1);

    while (n_items < 200 || n_msgs < 8) begin
      calm = ($urandom_range(0, 4) == 0);
      send_msg(pick_len(), 1'($urandom_range(0, 1)));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (words_pending != 0);
    repeat (200) @(posedge clk);

    if (fail_count == 0 && words_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
